@@ sv/assert_macros.svh @@
// assertion macros shared by the checker files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SDM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdm assertion failed");

// next-cycle implication, disabled while reset is low
`define SDM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdm assertion failed");

`endif

@@ sv/sdm_pkg.sv @@
// shared types, constants and codes of the distance map block
`default_nettype none
package sdm_pkg;

    localparam int GRID_SIDE       = 256;
    localparam int ROW_W           = $clog2(GRID_SIDE);
    localparam int GRID_AW         = 2 * ROW_W;
    localparam int GRID_CELLS      = GRID_SIDE * GRID_SIDE;
    localparam int KERNEL_MAX_HALF = 7;
    localparam int KT_SIDE         = KERNEL_MAX_HALF + 1;
    localparam int KT_IDX_W        = $clog2(KT_SIDE);
    localparam int KT_AW           = 2 * KT_IDX_W;
    localparam int KT_DEPTH        = KT_SIDE * KT_SIDE;
    localparam int DI_W            = KT_IDX_W + 1;

    localparam int DIST_W  = 16;
    localparam int COORD_W = 32;
    localparam int TRIG_W  = 16;
    localparam int CFG_W   = 32;
    localparam int ACC_W   = 50;
    localparam int PROD_W  = 64;
    localparam int CELL_W  = 38;
    localparam int Q_W     = 36;

    typedef enum logic [1:0] {
        OP_SPLAT  = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_KWRITE = 2'd3
    } t_op;

    localparam logic [2:0] REG_COS   = 3'd0;
    localparam logic [2:0] REG_SIN   = 3'd1;
    localparam logic [2:0] REG_TX    = 3'd2;
    localparam logic [2:0] REG_TY    = 3'd3;
    localparam logic [2:0] REG_RAD   = 3'd4;
    localparam logic [2:0] REG_INV   = 3'd5;
    localparam logic [2:0] REG_KHALF = 3'd6;
    localparam logic [2:0] REG_INIT  = 3'd7;

    typedef struct packed {
        logic signed [TRIG_W-1:0]  cos_theta;
        logic signed [TRIG_W-1:0]  sin_theta;
        logic signed [COORD_W-1:0] trans_x;
        logic signed [COORD_W-1:0] trans_y;
        logic [30:0]               grid_radius;
        logic [30:0]               inv_resolution;
        logic [2:0]                kernel_half;
        logic [DIST_W-1:0]         init_distance;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                operation;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic [7:0]                cell_row;
        logic [7:0]                cell_col;
        logic [DIST_W-1:0]         kernel_value;
    } t_item;

    typedef struct packed {
        logic                     done;
        logic signed [CELL_W-1:0] row;
        logic signed [CELL_W-1:0] col;
    } t_xf_res;

endpackage
`default_nettype wire

@@ sv/sdm_pt_if.sv @@
// input channel: one item per word
`default_nettype none
interface sdm_pt_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [7:0]  cell_row;
    logic [7:0]  cell_col;
    logic [15:0] kernel_value;

    modport source (output valid, operation, point_x, point_y, cell_row, cell_col,
                    kernel_value, input ready);
    modport sink   (input valid, operation, point_x, point_y, cell_row, cell_col,
                    kernel_value, output ready);
endinterface
`default_nettype wire

@@ sv/sdm_res_if.sv @@
// result channel: one cell distance per word
`default_nettype none
interface sdm_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_distance;

    modport source (output valid, cell_distance, input ready);
    modport sink   (input valid, cell_distance, output ready);
endinterface
`default_nettype wire

@@ sv/sdm_xform.sv @@
// pose transform and cell mapping on one shared multiplier, nine steps
`default_nettype none
module sdm_xform (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_px,
    input  wire logic signed [31:0] i_py,
    input  wire sdm_pkg::t_cfg      i_cfg,
    output sdm_pkg::t_xf_res        o_res
);
    localparam int STEP_LAST = 8;

    logic                               r_busy;
    logic [3:0]                         r_step;
    logic signed [sdm_pkg::COORD_W-1:0] r_px, r_py;
    logic signed [sdm_pkg::PROD_W-1:0]  r_prod;
    logic signed [sdm_pkg::ACC_W-1:0]   r_accx, r_accy;
    logic [sdm_pkg::PROD_W-1:0]         r_sum;
    logic                               r_done;
    logic signed [sdm_pkg::CELL_W-1:0]  r_row, r_col;

    logic signed [32:0]               w_a;
    logic signed [31:0]               w_b;
    logic signed [64:0]               w_mul;
    logic signed [33:0]               w_ofs_x, w_ofs_y;
    logic signed [sdm_pkg::ACC_W-1:0] w_base_x, w_base_y;
    logic [sdm_pkg::ACC_W-1:0]        w_abs_x, w_abs_y;
    logic [sdm_pkg::PROD_W-1:0]       w_tot;
    logic [sdm_pkg::Q_W-1:0]          w_q;
    logic signed [sdm_pkg::CELL_W-1:0] w_qs;
    logic signed [31:0]               w_inv;

    assign w_inv    = signed'({1'b0, i_cfg.inv_resolution});
    assign w_ofs_x  = 34'(i_cfg.trans_x) + signed'({3'b000, i_cfg.grid_radius});
    assign w_ofs_y  = 34'(i_cfg.trans_y) + signed'({3'b000, i_cfg.grid_radius});
    assign w_base_x = sdm_pkg::ACC_W'(signed'({w_ofs_x[33:0], 14'd0}));
    assign w_base_y = sdm_pkg::ACC_W'(signed'({w_ofs_y[33:0], 14'd0}));
    assign w_abs_x  = r_accx[sdm_pkg::ACC_W-1] ? unsigned'(-r_accx) : unsigned'(r_accx);
    assign w_abs_y  = r_accy[sdm_pkg::ACC_W-1] ? unsigned'(-r_accy) : unsigned'(r_accy);

    always_comb begin
        unique case (r_step)
            4'd0: begin w_a = 33'(r_px); w_b = 32'(i_cfg.cos_theta); end
            4'd1: begin w_a = 33'(r_py); w_b = 32'(i_cfg.sin_theta); end
            4'd2: begin w_a = 33'(r_px); w_b = 32'(i_cfg.sin_theta); end
            4'd3: begin w_a = 33'(r_py); w_b = 32'(i_cfg.cos_theta); end
            4'd4: begin w_a = signed'({7'd0, w_abs_x[sdm_pkg::ACC_W-1:24]}); w_b = w_inv; end
            4'd5: begin w_a = signed'({9'd0, w_abs_x[23:0]}); w_b = w_inv; end
            4'd6: begin w_a = signed'({7'd0, w_abs_y[sdm_pkg::ACC_W-1:24]}); w_b = w_inv; end
            4'd7: begin w_a = signed'({9'd0, w_abs_y[23:0]}); w_b = w_inv; end
            default: begin w_a = '0; w_b = '0; end
        endcase
    end

    assign w_mul = w_a * w_b;

    // quotient of the exact product: (hi*inv + (lo*inv >> 24)) >> 22
    assign w_tot = r_sum + {24'd0, r_prod[sdm_pkg::PROD_W-1:24]};
    assign w_q   = w_tot[22 +: sdm_pkg::Q_W];
    assign w_qs  = signed'({2'b00, w_q});

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul[sdm_pkg::PROD_W-1:0];
        if (i_start) begin
            r_px <= i_px;
            r_py <= i_py;
        end
        unique case (r_step)
            4'd1: r_accx <= sdm_pkg::ACC_W'(r_prod) + w_base_x;
            4'd2: r_accx <= r_accx - sdm_pkg::ACC_W'(r_prod);
            4'd3: r_accy <= sdm_pkg::ACC_W'(r_prod) + w_base_y;
            4'd4: r_accy <= r_accy + sdm_pkg::ACC_W'(r_prod);
            4'd5: r_sum  <= unsigned'(r_prod);
            4'd6: r_row  <= r_accx[sdm_pkg::ACC_W-1] ? -w_qs : w_qs;
            4'd7: r_sum  <= unsigned'(r_prod);
            4'd8: r_col  <= r_accy[sdm_pkg::ACC_W-1] ? -w_qs : w_qs;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == 4'(STEP_LAST));
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                if (r_step == 4'(STEP_LAST)) begin
                    r_busy <= 1'b0;
                end
                r_step <= r_step + 4'd1;
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.row  = r_row;
    assign o_res.col  = r_col;
endmodule
`default_nettype wire

@@ sv/sdm_core.sv @@
// grid and kernel memories, kernel walk, clearing pass and cell read
`default_nettype none
module sdm_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire sdm_pkg::t_cfg    i_cfg,
    input  wire logic             i_item_valid,
    output logic                  o_item_ready,
    input  wire sdm_pkg::t_item   i_item,
    output logic                  o_xf_start,
    input  wire sdm_pkg::t_xf_res i_xf,
    output logic                  o_rd_valid,
    input  wire logic             i_rd_ack,
    output logic [15:0]           o_rd_data
);
    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_XFORM = 6'b000100,
        S_WALK  = 6'b001000,
        S_DRAIN = 6'b010000,
        S_READ  = 6'b100000
    } t_state;

    t_state r_state, n_state;

    logic [sdm_pkg::DIST_W-1:0] r_grid [sdm_pkg::GRID_CELLS];
    logic [sdm_pkg::DIST_W-1:0] r_ktab [sdm_pkg::KT_DEPTH];
    logic [sdm_pkg::DIST_W-1:0] r_grid_q, r_k_q;

    logic [sdm_pkg::GRID_AW-1:0]       r_clr;
    logic signed [sdm_pkg::CELL_W-1:0] r_crow, r_ccol;
    logic signed [sdm_pkg::DI_W-1:0]   r_di, r_dj;
    logic                              r_wr_pend;
    logic [sdm_pkg::GRID_AW-1:0]       r_wr_addr;

    logic                              w_accept;
    logic [sdm_pkg::KT_IDX_W-1:0]      w_k;
    logic signed [sdm_pkg::DI_W-1:0]   w_kp, w_kn;
    logic signed [sdm_pkg::CELL_W-1:0] w_row, w_col;
    logic                              w_inb;
    logic [sdm_pkg::DI_W-1:0]          w_adi, w_adj;
    logic [sdm_pkg::GRID_AW-1:0]       w_walk_addr, w_ra, w_wa;
    logic                              w_re, w_we, w_kwe;
    logic [sdm_pkg::DIST_W-1:0]        w_wd;
    logic [sdm_pkg::KT_AW-1:0]         w_kra, w_kwa;
    logic                              w_last;

    assign o_item_ready = (r_state == S_IDLE);
    assign w_accept     = i_item_valid && o_item_ready;
    assign o_xf_start   = w_accept && (i_item.operation == sdm_pkg::OP_SPLAT);
    assign o_rd_valid   = (r_state == S_READ);
    assign o_rd_data    = r_grid_q;

    assign w_k  = (int'(i_cfg.kernel_half) > sdm_pkg::KERNEL_MAX_HALF)
                  ? sdm_pkg::KT_IDX_W'(sdm_pkg::KERNEL_MAX_HALF)
                  : sdm_pkg::KT_IDX_W'(i_cfg.kernel_half);
    assign w_kp = signed'({1'b0, w_k});
    assign w_kn = -w_kp;

    // current kernel cell and its bounds
    assign w_row = r_crow + sdm_pkg::CELL_W'(r_di);
    assign w_col = r_ccol + sdm_pkg::CELL_W'(r_dj);
    assign w_inb = (w_row >= 0) && (w_row < sdm_pkg::CELL_W'(sdm_pkg::GRID_SIDE))
                && (w_col >= 0) && (w_col < sdm_pkg::CELL_W'(sdm_pkg::GRID_SIDE));
    assign w_walk_addr = {w_row[sdm_pkg::ROW_W-1:0], w_col[sdm_pkg::ROW_W-1:0]};
    assign w_adi = r_di[sdm_pkg::DI_W-1] ? unsigned'(-r_di) : unsigned'(r_di);
    assign w_adj = r_dj[sdm_pkg::DI_W-1] ? unsigned'(-r_dj) : unsigned'(r_dj);
    assign w_kra = {w_adi[sdm_pkg::KT_IDX_W-1:0], w_adj[sdm_pkg::KT_IDX_W-1:0]};
    assign w_last = (r_di == w_kp) && (r_dj == w_kp);

    assign w_re = (r_state == S_IDLE) || (r_state == S_WALK);
    assign w_ra = (r_state == S_WALK) ? w_walk_addr
                                      : {i_item.cell_row[sdm_pkg::ROW_W-1:0],
                                         i_item.cell_col[sdm_pkg::ROW_W-1:0]};

    // clearing pass owns the write port, otherwise the min write-back
    always_comb begin
        if (r_state == S_CLEAR) begin
            w_we = 1'b1;
            w_wa = r_clr;
            w_wd = i_cfg.init_distance;
        end else begin
            w_we = r_wr_pend && (r_k_q < r_grid_q);
            w_wa = r_wr_addr;
            w_wd = r_k_q;
        end
    end

    assign w_kwe = w_accept && (i_item.operation == sdm_pkg::OP_KWRITE)
                && (int'(i_item.cell_row) <= sdm_pkg::KERNEL_MAX_HALF)
                && (int'(i_item.cell_col) <= sdm_pkg::KERNEL_MAX_HALF);
    assign w_kwa = {i_item.cell_row[sdm_pkg::KT_IDX_W-1:0],
                    i_item.cell_col[sdm_pkg::KT_IDX_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_grid[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_grid_q <= r_grid[w_ra];
        end
        if (w_kwe) begin
            r_ktab[w_kwa] <= i_item.kernel_value;
        end
        r_k_q <= r_ktab[w_kra];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (&r_clr) n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_item.operation)
                        sdm_pkg::OP_SPLAT:  n_state = S_XFORM;
                        sdm_pkg::OP_READ:   n_state = S_READ;
                        sdm_pkg::OP_CLEAR:  n_state = S_CLEAR;
                        sdm_pkg::OP_KWRITE: n_state = S_IDLE;
                        default:            n_state = S_IDLE;
                    endcase
                end
            end
            S_XFORM: if (i_xf.done) n_state = S_WALK;
            S_WALK:  if (w_last) n_state = S_DRAIN;
            S_DRAIN: n_state = S_IDLE;
            S_READ:  if (i_rd_ack) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_wr_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_pend <= (r_state == S_WALK) && w_inb;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end else begin
                r_clr <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= w_walk_addr;
        if (r_state == S_XFORM && i_xf.done) begin
            r_crow <= i_xf.row;
            r_ccol <= i_xf.col;
            r_di   <= w_kn;
            r_dj   <= w_kn;
        end else if (r_state == S_WALK) begin
            if (r_dj == w_kp) begin
                r_dj <= w_kn;
                r_di <= r_di + 1'b1;
            end else begin
                r_dj <= r_dj + 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

@@ sv/scan_distance_map_splat.sv @@
// top level: configuration registers, channels and result register
// Usage:
//  i_pt carries one item per word: operation 0 splats a point, 1 reads a cell,
//  2 clears the grid to init_distance, 3 writes one kernel quadrant entry.
//  o_res carries one cell_distance word for every read, nothing for the rest.
//  Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while idle.
//  Sequence: a splat runs the transform (nine steps on one shared multiplier
//  and a done flag), then read-modify-write of the (2K+1)^2 kernel cells on
//  the grid memory, one cell per cycle, then one drain state. A read latches
//  its cell from the grid memory and then loads it into the result register;
//  a kernel write lands at acceptance. A clear sweeps the 65536-cell grid,
//  one cell a cycle. Reset: registers take their defaults and the same
//  clearing pass runs; i_pt.ready stays low until it ends.
//  A stalled receiver holds the result in the output register; splats, clears
//  and kernel writes go on, the next read is taken but then holds the input
//  until the register is free.
`default_nettype none
module scan_distance_map_splat (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sdm_pt_if.sink           i_pt,
    sdm_res_if.source        o_res,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);
    sdm_pkg::t_cfg    r_cfg;
    sdm_pkg::t_item   w_item;
    sdm_pkg::t_xf_res w_xf;
    logic             w_item_ready, w_xf_start, w_rd_valid, w_rd_ack;
    logic [15:0]      w_rd_data;
    logic             r_out_valid;
    logic [15:0]      r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cos_theta      <= 16'sd16384;
            r_cfg.sin_theta      <= '0;
            r_cfg.trans_x        <= '0;
            r_cfg.trans_y        <= '0;
            r_cfg.grid_radius    <= 31'd655360;
            r_cfg.inv_resolution <= 31'd655360;
            r_cfg.kernel_half    <= 3'd3;
            r_cfg.init_distance  <= 16'd2048;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sdm_pkg::REG_COS:   r_cfg.cos_theta      <= signed'(i_cfg_data[15:0]);
                sdm_pkg::REG_SIN:   r_cfg.sin_theta      <= signed'(i_cfg_data[15:0]);
                sdm_pkg::REG_TX:    r_cfg.trans_x        <= signed'(i_cfg_data);
                sdm_pkg::REG_TY:    r_cfg.trans_y        <= signed'(i_cfg_data);
                sdm_pkg::REG_RAD:   r_cfg.grid_radius    <= i_cfg_data[30:0];
                sdm_pkg::REG_INV:   r_cfg.inv_resolution <= i_cfg_data[30:0];
                sdm_pkg::REG_KHALF: r_cfg.kernel_half    <= i_cfg_data[2:0];
                sdm_pkg::REG_INIT:  r_cfg.init_distance  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign w_item.operation    = i_pt.operation;
    assign w_item.point_x      = i_pt.point_x;
    assign w_item.point_y      = i_pt.point_y;
    assign w_item.cell_row     = i_pt.cell_row;
    assign w_item.cell_col     = i_pt.cell_col;
    assign w_item.kernel_value = i_pt.kernel_value;
    assign i_pt.ready          = w_item_ready;

    sdm_xform u_xform (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_xf_start),
        .i_px    (i_pt.point_x),
        .i_py    (i_pt.point_y),
        .i_cfg   (r_cfg),
        .o_res   (w_xf)
    );

    sdm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_item_valid (i_pt.valid),
        .o_item_ready (w_item_ready),
        .i_item       (w_item),
        .o_xf_start   (w_xf_start),
        .i_xf         (w_xf),
        .o_rd_valid   (w_rd_valid),
        .i_rd_ack     (w_rd_ack),
        .o_rd_data    (w_rd_data)
    );

    // result register frees when empty or taken this cycle
    assign w_rd_ack = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_rd_valid && w_rd_ack) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_valid && w_rd_ack) begin
            r_out_data <= w_rd_data;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.cell_distance = r_out_data;
endmodule
`default_nettype wire

@@ sv/sdm_checker.sv @@
// port-level checks of the distance map block and their binding
`default_nettype none
`include "assert_macros.svh"
module sdm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic [1:0]  i_in_op,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_out_data
);
    logic w_in_acc;
    assign w_in_acc = i_in_valid && i_in_ready;

    `SDM_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `SDM_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_data))
    `SDM_ASSERT_IMP(a_rst_clear, i_clk, i_rst_n, !$past(i_rst_n), !i_in_ready)
    `SDM_ASSERT_NXT(a_clear_busy, i_clk, i_rst_n, w_in_acc && i_in_op == sdm_pkg::OP_CLEAR, !i_in_ready)
    `SDM_ASSERT_NXT(a_splat_busy, i_clk, i_rst_n, w_in_acc && i_in_op == sdm_pkg::OP_SPLAT, !i_in_ready)
endmodule

bind scan_distance_map_splat sdm_checker u_sdm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pt.valid),
    .i_in_ready  (i_pt.ready),
    .i_in_op     (i_pt.operation),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.cell_distance)
);
`default_nettype wire
